/* rtl/ptp_pkg.sv */
// Shared types, constants and fixed-point helpers for the point transform block.
package ptp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int BAD_VALUE_DEF = -10000;
    localparam int QUO_BITS      = 32;
    // divider: prep stage, one stage per quotient bit, sign/saturate stage
    localparam int DIV_STAGES    = QUO_BITS + 2;
    localparam int ST_PREP       = 2;
    localparam int ST_MUL        = ST_PREP + DIV_STAGES;
    localparam int PIPE_STAGES   = ST_MUL + 2;

    typedef enum logic [2:0] {
        REG_MAT_A   = 3'd0,
        REG_MAT_B   = 3'd1,
        REG_MAT_C   = 3'd2,
        REG_MAT_D   = 3'd3,
        REG_MAT_E   = 3'd4,
        REG_MAT_F   = 3'd5,
        REG_VIEW_XY = 3'd6,
        REG_VIEW_Z  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic               ovf;
        logic               proj;
        logic               behind;
    } sb_t;

    // Product scaled down by frac (floor), saturated; bit 32 flags saturation.
    function automatic logic [32:0] fix_scale(input logic signed [63:0] p, input int frac);
        logic signed [63:0] r;
        r = p >>> frac;
        if (r > 64'sh0000_0000_7FFF_FFFF)
            return {1'b1, 32'h7FFF_FFFF};
        else if (r < -64'sh0000_0000_8000_0000)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, r[31:0]};
    endfunction

endpackage

/* rtl/point_transform_perspective.sv */
// Top level: config registers, pipeline flow control, lanes, dividers and merge.
//
// Streams one point per cycle unless the output stalls: each point is transformed
// by the 4x3 matrix and, when view_z is nonzero, projected toward the viewer or,
// if it lies behind, marked as behind. The pipeline depth is dominated by the divider
// pipelines (one quotient bit per stage, 32 stages plus prep and saturation).
// Every stage stalls only when its successor is full, so bubbles are squeezed out
// and new points are taken while a result waits. Configuration is meant to be
// written while no point is in flight.
module point_transform_perspective import ptp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BAD_VALUE = BAD_VALUE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // src_x, src_y, src_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // out_x, out_y, out_z, pre_x, pre_y, pre_z
    output logic [1:0]   m_tuser    // behind, overflow
);

    logic [63:0] mat_a_reg, mat_b_reg, mat_c_reg, mat_d_reg, mat_e_reg, mat_f_reg;
    logic [63:0] view_xy_reg;
    logic [31:0] view_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_a_reg   <= 64'd65536;
            mat_b_reg   <= '0;
            mat_c_reg   <= 64'd65536;
            mat_d_reg   <= '0;
            mat_e_reg   <= 64'd65536;
            mat_f_reg   <= '0;
            view_xy_reg <= '0;
            view_z_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAT_A:   mat_a_reg   <= cfg_data;
                REG_MAT_B:   mat_b_reg   <= cfg_data;
                REG_MAT_C:   mat_c_reg   <= cfg_data;
                REG_MAT_D:   mat_d_reg   <= cfg_data;
                REG_MAT_E:   mat_e_reg   <= cfg_data;
                REG_MAT_F:   mat_f_reg   <= cfg_data;
                REG_VIEW_XY: view_xy_reg <= cfg_data;
                REG_VIEW_Z:  view_z_reg  <= cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    // stage occupancy and load enables
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] ld;

    always_comb
    begin
        ld[PIPE_STAGES-1] = ~valid_reg[PIPE_STAGES-1] | m_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
            ld[k] = ~valid_reg[k] | ld[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ld[0])
                valid_reg[0] <= s_tvalid;
            for (int k = 1; k < PIPE_STAGES; k++)
                if (ld[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign s_tready = ld[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    logic signed [31:0] sx, sy, sz;
    assign sx = signed'(s_tdata[31:0]);
    assign sy = signed'(s_tdata[63:32]);
    assign sz = signed'(s_tdata[95:64]);

    logic signed [31:0] t0, t1, t2;
    logic               o0, o1, o2;

    ptp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk(clk), .ld_mul(ld[0]), .ld_sum(ld[1]),
        .src_x(sx), .src_y(sy), .src_z(sz),
        .m0(signed'(mat_a_reg[31:0])), .m1(signed'(mat_b_reg[63:32])),
        .m2(signed'(mat_d_reg[31:0])), .trans(signed'(mat_e_reg[63:32])),
        .t(t0), .t_ovf(o0)
    );

    ptp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk(clk), .ld_mul(ld[0]), .ld_sum(ld[1]),
        .src_x(sx), .src_y(sy), .src_z(sz),
        .m0(signed'(mat_a_reg[63:32])), .m1(signed'(mat_c_reg[31:0])),
        .m2(signed'(mat_d_reg[63:32])), .trans(signed'(mat_f_reg[31:0])),
        .t(t1), .t_ovf(o1)
    );

    ptp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk(clk), .ld_mul(ld[0]), .ld_sum(ld[1]),
        .src_x(sx), .src_y(sy), .src_z(sz),
        .m0(signed'(mat_b_reg[31:0])), .m1(signed'(mat_c_reg[63:32])),
        .m2(signed'(mat_e_reg[31:0])), .trans(signed'(mat_f_reg[63:32])),
        .t(t2), .t_ovf(o2)
    );

    logic signed [31:0] den;
    logic               vz_on;
    assign den   = signed'(view_z_reg - t2);
    assign vz_on = view_z_reg != 32'd0;

    // sideband riding alongside the dividers
    sb_t sb_reg [ST_PREP:ST_MUL-1];

    always_ff @(posedge clk)
    begin
        if (ld[ST_PREP])
        begin
            sb_reg[ST_PREP].t0     <= t0;
            sb_reg[ST_PREP].t1     <= t1;
            sb_reg[ST_PREP].t2     <= t2;
            sb_reg[ST_PREP].ovf    <= o0 | o1 | o2;
            sb_reg[ST_PREP].proj   <= vz_on & den[31];
            sb_reg[ST_PREP].behind <= vz_on & ~den[31];
        end
        for (int k = ST_PREP + 1; k < ST_MUL; k++)
            if (ld[k])
                sb_reg[k] <= sb_reg[k-1];
    end

    logic signed [31:0] qx, qy, qz;
    logic               qox, qoy, qoz;

    ptp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk(clk), .ld(ld[ST_MUL-1:ST_PREP]),
        .a(signed'(view_xy_reg[31:0])), .d(den), .q(qx), .q_ovf(qox)
    );

    ptp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk(clk), .ld(ld[ST_MUL-1:ST_PREP]),
        .a(signed'(view_xy_reg[63:32])), .d(den), .q(qy), .q_ovf(qoy)
    );

    ptp_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .clk(clk), .ld(ld[ST_MUL-1:ST_PREP]),
        .a(signed'(view_z_reg)), .d(den), .q(qz), .q_ovf(qoz)
    );

    ptp_merge #(.FRAC_BITS(FRAC_BITS), .BAD_VALUE(BAD_VALUE)) u_merge (
        .clk(clk), .ld_mul(ld[ST_MUL]), .ld_out(ld[ST_MUL+1]),
        .sb(sb_reg[ST_MUL-1]), .qx(qx), .qy(qy), .qz(qz),
        .q_ovf(qox | qoy | qoz),
        .data(m_tdata), .flags(m_tuser)
    );

endmodule

/* rtl/ptp_lane.sv */
// One output column of the affine transform: three multiplies and the sum.
module ptp_lane import ptp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               ld_mul,
    input  logic               ld_sum,
    input  logic signed [31:0] src_x,
    input  logic signed [31:0] src_y,
    input  logic signed [31:0] src_z,
    input  logic signed [31:0] m0,
    input  logic signed [31:0] m1,
    input  logic signed [31:0] m2,
    input  logic signed [31:0] trans,
    output logic signed [31:0] t,
    output logic               t_ovf
);

    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [31:0] t_reg, t_next;
    logic               ovf_reg, ovf_next;
    logic [32:0]        f0, f1, f2;

    always_ff @(posedge clk)
    begin
        if (ld_mul)
        begin
            p0_reg <= 64'(src_x) * 64'(m0);
            p1_reg <= 64'(src_y) * 64'(m1);
            p2_reg <= 64'(src_z) * 64'(m2);
        end
        if (ld_sum)
        begin
            t_reg   <= t_next;
            ovf_reg <= ovf_next;
        end
    end

    always_comb
    begin
        f0       = fix_scale(p0_reg, FRAC_BITS);
        f1       = fix_scale(p1_reg, FRAC_BITS);
        f2       = fix_scale(p2_reg, FRAC_BITS);
        t_next   = signed'(f0[31:0] + f1[31:0] + f2[31:0] + trans);
        ovf_next = f0[32] | f1[32] | f2[32];
    end

    assign t     = t_reg;
    assign t_ovf = ovf_reg;

endmodule

/* rtl/ptp_div.sv */
// Pipelined fixed-point divider, (a << FRAC_BITS) / d for negative d, one quotient bit per stage.
module ptp_div import ptp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] ld,
    input  logic signed [31:0]    a,
    input  logic signed [31:0]    d,
    output logic signed [31:0]    q,
    output logic                  q_ovf
);

    logic [63:0] rem_reg [0:QUO_BITS];
    logic [31:0] quo_reg [0:QUO_BITS];
    logic [31:0] dm_reg  [0:QUO_BITS];
    logic        big_reg [0:QUO_BITS];
    logic        neg_reg [0:QUO_BITS];
    logic signed [31:0] q_reg;
    logic        ovf_reg;

    logic [31:0] a_mag, d_mag;
    logic [63:0] n_mag;

    always_comb
    begin
        a_mag = a[31] ? 32'(-a) : 32'(a);
        d_mag = d[31] ? 32'(-d) : 32'(d);
        n_mag = {32'b0, a_mag} << FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            rem_reg[0] <= n_mag;
            quo_reg[0] <= '0;
            dm_reg[0]  <= d_mag;
            big_reg[0] <= n_mag >= {d_mag, 32'b0};
            neg_reg[0] <= ~a[31] & (a != 32'sd0);
        end
    end

    for (genvar k = 1; k <= QUO_BITS; k++)
    begin : g_bit
        localparam int B = QUO_BITS - k;
        logic [63:0] dsh;
        logic        take;
        assign dsh  = {32'b0, dm_reg[k-1]} << B;
        assign take = rem_reg[k-1] >= dsh;
        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                rem_reg[k] <= take ? rem_reg[k-1] - dsh : rem_reg[k-1];
                quo_reg[k] <= quo_reg[k-1] | (take ? (32'd1 << B) : 32'd0);
                dm_reg[k]  <= dm_reg[k-1];
                big_reg[k] <= big_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    logic [31:0] u;
    logic        fin_big, fin_neg;
    assign u       = quo_reg[QUO_BITS];
    assign fin_big = big_reg[QUO_BITS];
    assign fin_neg = neg_reg[QUO_BITS];

    always_ff @(posedge clk)
    begin
        if (ld[DIV_STAGES-1])
        begin
            if (fin_neg)
            begin
                if (fin_big || u > 32'h8000_0000)
                begin
                    q_reg   <= 32'sh8000_0000;
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    q_reg   <= signed'(32'(-u));
                    ovf_reg <= 1'b0;
                end
            end
            else
            begin
                if (fin_big || u > 32'h7FFF_FFFF)
                begin
                    q_reg   <= 32'sh7FFF_FFFF;
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    q_reg   <= signed'(u);
                    ovf_reg <= 1'b0;
                end
            end
        end
    end

    assign q     = q_reg;
    assign q_ovf = ovf_reg;

endmodule

/* rtl/ptp_merge.sv */
// Merge stage: projection multiplies, behind-viewer marking and flag collection.
module ptp_merge import ptp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BAD_VALUE = BAD_VALUE_DEF
) (
    input  logic               clk,
    input  logic               ld_mul,
    input  logic               ld_out,
    input  sb_t                sb,
    input  logic signed [31:0] qx,
    input  logic signed [31:0] qy,
    input  logic signed [31:0] qz,
    input  logic               q_ovf,
    output logic [191:0]       data,
    output logic [1:0]         flags
);

    localparam logic signed [63:0] BAD_WIDE = 64'(BAD_VALUE) * (64'sd1 <<< FRAC_BITS);
    localparam logic [31:0]        BAD_WORD = BAD_WIDE[31:0];

    logic signed [63:0] pxa_reg, pxb_reg, pya_reg, pyb_reg;
    sb_t                sb_reg;
    logic               qovf_reg;
    logic [191:0]       data_reg, data_next;
    logic [1:0]         flags_reg, flags_next;
    logic [32:0]        fxa, fxb, fya, fyb;
    logic [31:0]        ox, oy, oz;
    logic               povf;

    always_ff @(posedge clk)
    begin
        if (ld_mul)
        begin
            pxa_reg  <= 64'(sb.t0) * 64'(qz);
            pxb_reg  <= 64'(qx) * 64'(sb.t2);
            pya_reg  <= 64'(sb.t1) * 64'(qz);
            pyb_reg  <= 64'(qy) * 64'(sb.t2);
            sb_reg   <= sb;
            qovf_reg <= q_ovf;
        end
        if (ld_out)
        begin
            data_reg  <= data_next;
            flags_reg <= flags_next;
        end
    end

    always_comb
    begin
        fxa  = fix_scale(pxa_reg, FRAC_BITS);
        fxb  = fix_scale(pxb_reg, FRAC_BITS);
        fya  = fix_scale(pya_reg, FRAC_BITS);
        fyb  = fix_scale(pyb_reg, FRAC_BITS);
        povf = qovf_reg | fxa[32] | fxb[32] | fya[32] | fyb[32];
        ox   = sb_reg.t0;
        oy   = sb_reg.t1;
        oz   = sb_reg.t2;
        if (sb_reg.behind)
        begin
            ox = BAD_WORD;
            oy = BAD_WORD;
            oz = BAD_WORD;
        end
        else if (sb_reg.proj)
        begin
            ox = fxa[31:0] - fxb[31:0];
            oy = fya[31:0] - fyb[31:0];
        end
        data_next  = {sb_reg.t2, sb_reg.t1, sb_reg.t0, oz, oy, ox};
        flags_next = {sb_reg.ovf | (sb_reg.proj & povf), sb_reg.behind};
    end

    assign data  = data_reg;
    assign flags = flags_reg;

endmodule

/* verif/point_transform_perspective_test.sv */
// Self-checking stream testbench for point_transform_perspective with a built-in fixed-point predictor.
module point_transform_perspective_test;
    import ptp_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int LATENCY   = 38;
    localparam int MAX_CYCLE = 600000;

    typedef struct {
        logic [31:0] x, y, z;
    } point_t;

    typedef struct {
        logic [31:0] ox, oy, oz, px, py, pz;
        logic        bh, ov;
    } point_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;     // src_x, src_y, src_z
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;          // out_x, out_y, out_z, pre_x, pre_y, pre_z
    logic [1:0]   m_tuser;          // behind, overflow

    point_transform_perspective u_dut (.*);

    point_t        pend_q[$];
    point_result_t proj_q[$];
    logic [63:0]   cfg_copy[8];
    int            errors = 0;
    int            cycles = 0;
    bit            quiet = 0;
    int            src_gap = 0;
    int            dst_gap = 0;

    initial forever #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] fx_sat(input longint r, inout logic ov);
        if (r > 64'sd2147483647)
        begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (r < -64'sd2147483648)
        begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    // floor((a*b) / 2^FRAC)
    function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b,
                                           inout logic ov);
        longint sa, sb, p;
        sa = $signed(a);
        sb = $signed(b);
        p = sa * sb;
        return fx_sat(p >>> FRAC, ov);
    endfunction

    // (a*2^FRAC)/b truncated toward zero; b is never zero here
    function automatic logic [31:0] fx_div(input logic [31:0] a, input logic [31:0] b,
                                           inout logic ov);
        longint n, d;
        n = $signed(a);
        n = n * (64'sd1 << FRAC);
        d = $signed(b);
        return fx_sat(n / d, ov);
    endfunction

    function automatic point_result_t project_point(input point_t p);
        point_result_t r;
        logic [31:0] m[12];
        logic [31:0] s[3];
        logic [31:0] t[3];
        logic [31:0] vz, den, qx, qy, qz, bad;
        logic ov;
        for (int k = 0; k < 6; k++)
        begin
            m[2*k]   = cfg_copy[k][31:0];
            m[2*k+1] = cfg_copy[k][63:32];
        end
        s[0] = p.x;
        s[1] = p.y;
        s[2] = p.z;
        ov = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            t[j] = m[9+j];
            for (int i = 0; i < 3; i++)
                t[j] = t[j] + fx_mul(s[i], m[3*i+j], ov);
        end
        r.px = t[0];
        r.py = t[1];
        r.pz = t[2];
        r.ox = t[0];
        r.oy = t[1];
        r.oz = t[2];
        r.bh = 1'b0;
        vz = cfg_copy[REG_VIEW_Z][31:0];
        if (vz != 0)
        begin
            den = vz - t[2];
            if (!den[31])
            begin
                bad = 32'(longint'(BAD_VALUE_DEF) * (64'sd1 << FRAC));
                r.ox = bad;
                r.oy = bad;
                r.oz = bad;
                r.bh = 1'b1;
            end
            else
            begin
                qx = fx_div(cfg_copy[REG_VIEW_XY][31:0], den, ov);
                qy = fx_div(cfg_copy[REG_VIEW_XY][63:32], den, ov);
                qz = fx_div(vz, den, ov);
                r.ox = fx_mul(t[0], qz, ov) - fx_mul(qx, t[2], ov);
                r.oy = fx_mul(t[1], qz, ov) - fx_mul(qy, t[2], ov);
            end
        end
        r.ov = ov;
        return r;
    endfunction

    // source side
    always @(posedge clk)
    begin
        logic nv;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                proj_q.push_back(project_point(pend_q[0]));
                pend_q.pop_front();
            end
            if (s_tvalid && !s_tready)
                nv = 1'b1;
            else if (src_gap > 0)
            begin
                src_gap--;
                nv = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                src_gap = $urandom_range(1, 18) - 1;
                nv = 1'b0;
            end
            else
                nv = (pend_q.size() > 0);
            s_tvalid <= nv;
            if (nv)
                s_tdata <= {pend_q[0].z, pend_q[0].y, pend_q[0].x};
        end
    end

    // result side
    always @(posedge clk)
    begin
        point_result_t e;
        logic nr;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (proj_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction: %h %b", m_tdata, m_tuser);
                end
                else
                begin
                    e = proj_q.pop_front();
                    if (m_tdata !== {e.pz, e.py, e.px, e.oz, e.oy, e.ox}
                        || m_tuser !== {e.ov, e.bh})
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %h %b%b got %h %b",
                                     {e.pz, e.py, e.px, e.oz, e.oy, e.ox}, e.ov, e.bh,
                                     m_tdata, m_tuser);
                    end
                end
            end
            if (dst_gap > 0)
            begin
                dst_gap--;
                nr = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                dst_gap = $urandom_range(1, 18) - 1;
                nr = 1'b0;
            end
            else
                nr = 1'b1;
            m_tready <= nr;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_copy[idx] = (idx == REG_VIEW_Z) ? {32'd0, val[31:0]} : val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || proj_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 12) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(input int mode);
        case ($urandom_range(0, mode))
            0: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            1: return 32'h0001_0000 + $urandom_range(0, 32'h4000) - 32'h2000;
            2: return $urandom;
            default:
                case ($urandom_range(0, 4))
                    0: return 32'h0;
                    1: return 32'h1;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
        endcase
    endfunction

    task automatic push_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pend_q.push_back(p);
    endtask

    // kind 0: near identity, 1: wide random, 2: full random + extremes
    task automatic random_setup(input int kind, input bit persp);
        logic [31:0] vz;
        for (int k = 0; k < 7; k++)
            write_reg(cfg_reg_t'(k), {rand_word(kind == 0 ? 1 : kind + 1),
                                      rand_word(kind == 0 ? 1 : kind + 1)});
        vz = persp ? rand_word(kind + 1) : 32'h0;
        if (persp && vz == 0)
            vz = 32'h0000_0100;
        write_reg(REG_VIEW_Z, {$urandom, vz});
    endtask

    task automatic random_points(input int n, input int kind);
        logic [31:0] vz;
        vz = cfg_copy[REG_VIEW_Z][31:0];
        for (int i = 0; i < n; i++)
        begin
            if (vz != 0 && $urandom_range(0, 1))
                push_point(rand_word(kind + 1), rand_word(kind + 1),
                           vz + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
            else
                push_point(rand_word(kind + 1), rand_word(kind + 1), rand_word(kind + 1));
        end
    endtask

    initial
    begin
        cfg_copy[REG_MAT_A] = 64'd65536;
        cfg_copy[REG_MAT_B] = 64'd0;
        cfg_copy[REG_MAT_C] = 64'd65536;
        cfg_copy[REG_MAT_D] = 64'd0;
        cfg_copy[REG_MAT_E] = 64'd65536;
        cfg_copy[REG_MAT_F] = 64'd0;
        cfg_copy[REG_VIEW_XY] = 64'd0;
        cfg_copy[REG_VIEW_Z] = 64'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset matrix, no projection: field extremes
        push_point(32'h0, 32'h0, 32'h0);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_point(32'hFFFF_FFFF, 32'h1, 32'hFFFF_0000);
        drain();

        // overflow in the transform multiplies
        for (int k = 0; k < 6; k++)
            write_reg(cfg_reg_t'(k), 64'h7FFF_FFFF_8000_0000);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_point(32'h0, 32'h0, 32'h0);
        drain();

        // identity matrix with viewer at z = 10: behind, on the plane, in front
        write_reg(REG_MAT_A, 64'h0000_0000_0001_0000);
        write_reg(REG_MAT_B, 64'h0);
        write_reg(REG_MAT_C, 64'h0000_0000_0001_0000);
        write_reg(REG_MAT_D, 64'h0);
        write_reg(REG_MAT_E, 64'h0000_0000_0001_0000);
        write_reg(REG_MAT_F, 64'h0);
        write_reg(REG_VIEW_XY, 64'hFFFE_0000_0003_0000);
        write_reg(REG_VIEW_Z, 64'h0000_0000_000A_0000);
        push_point(32'h0005_0000, 32'h0002_0000, 32'h0);
        push_point(32'h0005_0000, 32'h0002_0000, 32'h000A_0000);
        push_point(32'h0005_0000, 32'h0002_0000, 32'h000A_0001);
        push_point(32'h0005_0000, 32'hFFFD_0000, 32'h0014_0000);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h000A_0001);
        push_point(32'h1, 32'h1, 32'h7FFF_FFFF);
        drain();

        // viewer at the z extremes, divider overflow
        write_reg(REG_VIEW_XY, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_VIEW_Z, 64'h0000_0000_8000_0000);
        push_point(32'h0, 32'h0, 32'h8000_0001);
        push_point(32'h0, 32'h0, 32'h0);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        write_reg(REG_VIEW_Z, 64'hFFFF_FFFF_7FFF_FFFF);
        push_point(32'h0, 32'h0, 32'h7FFF_FFFF);
        push_point(32'h0, 32'h0, 32'h8000_0000);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            random_setup(ph % 3, ph != 0 && ph != 4);
            random_points(140, ph % 3);
            drain();
        end

        quiet = 1;
        random_setup(1, 1'b1);
        random_points(60, 1);
        drain();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
